### hdl/bpdp_pkg.sv
package bpdp_pkg;

    localparam int MAX_SUCCESSES = 255;
    localparam int MAX_TRIALS    = 4095;
    localparam int ROW_DEPTH     = MAX_SUCCESSES + 1;
    localparam int ROW_AW        = $clog2(ROW_DEPTH);
    localparam int VAL_W         = 32;
    localparam int PROB_W        = 17;
    localparam int PROD_W        = VAL_W + PROB_W;
    localparam int FRAC_P        = 16;

    localparam logic [VAL_W-1:0]  ONE_Q31  = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  ZERO_Q31 = 32'h0000_0000;
    localparam logic [PROB_W-1:0] ONE_Q16  = 17'h1_0000;
    localparam logic [PROB_W-1:0] HALF_Q16 = 17'h0_8000;

endpackage

### hdl/bpdp_ram.sv
module bpdp_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hdl/binomial_probability_dp.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    trial_count[11:0], success_count[7:0]
// out       output     out_valid / out_stall  probability[31:0] (Q1.31)
// cfg       input      cfg_valid / cfg_ready  prob_success[16:0] (Q1.16)
//
// A request steps through n rows of the recurrence for n trials and k successes;
// the single shared 17x32 multiplier and the one read port of the row store pace it.
// Requests with k > n return 0 without running the recurrence.
// rst_n is asynchronous; reset sets p to 0.5 and idles the sequencer.
// in_stall is high while a request is in work; out_stall holds the result register.
module binomial_probability_dp
    import bpdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [11:0]          trial_count,
    input  logic [7:0]           success_count,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [VAL_W-1:0]     probability,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PROB_W-1:0]    prob_success
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_RD_TOP,
        S_LOAD,
        S_MUL_Q,
        S_MUL_P,
        S_WRITE,
        S_MUL_Q0,
        S_WRITE0,
        S_RD_RES,
        S_RES,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [PROB_W-1:0]   cfg_p_reg;
    logic [PROB_W-1:0]   p_reg;
    logic [PROB_W-1:0]   q_reg;
    logic [11:0]         n_reg;
    logic [11:0]         i_reg;
    logic [ROW_AW-1:0]   k_reg;
    logic [ROW_AW-1:0]   j_reg;
    logic [VAL_W-1:0]    cur_reg;
    logic [VAL_W-1:0]    lower_reg;
    logic [VAL_W-1:0]    term_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VAL_W-1:0]    res_reg;
    logic                out_valid_reg;
    logic [VAL_W-1:0]    probability_reg;

    logic                ram_wr_en;
    logic [ROW_AW-1:0]   ram_wr_addr;
    logic [VAL_W-1:0]    ram_wr_data;
    logic [ROW_AW-1:0]   ram_rd_addr;
    logic [VAL_W-1:0]    ram_rd_data;

    logic [PROB_W-1:0]   mul_w;
    logic [VAL_W-1:0]    mul_v;
    logic [PROD_W-1:0]   mul_out;
    logic [VAL_W-1:0]    prod_hi;
    logic [PROB_W-1:0]   p_sat;
    logic                in_range;
    logic                out_free;

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign probability = probability_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    assign p_sat    = (cfg_p_reg > ONE_Q16) ? ONE_Q16 : cfg_p_reg;
    assign in_range = (int'(trial_count) <= MAX_TRIALS)
                   && (int'(success_count) <= MAX_SUCCESSES)
                   && ({4'd0, success_count} <= trial_count);

    assign mul_w   = (state_reg == S_MUL_P) ? p_reg : q_reg;
    assign mul_v   = (state_reg == S_MUL_P) ? lower_reg : cur_reg;
    assign mul_out = PROD_W'(mul_w) * PROD_W'(mul_v);
    assign prod_hi = prod_reg[FRAC_P +: VAL_W];

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = j_reg;
        ram_wr_data = ZERO_Q31;
        ram_rd_addr = k_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = (j_reg == '0) ? ONE_Q31 : ZERO_Q31;
            end
            S_LOAD:
            begin
                ram_rd_addr = j_reg - ROW_AW'(1);
            end
            S_WRITE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = term_reg + prod_hi;
                ram_rd_addr = j_reg - ROW_AW'(2);
            end
            S_WRITE0:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = prod_hi;
            end
            default:
            begin
                ram_rd_addr = k_reg;
            end
        endcase
    end

    bpdp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_p_reg     <= HALF_Q16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_p_reg <= prob_success;
            end
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        n_reg <= trial_count;
                        k_reg <= ROW_AW'(success_count);
                        p_reg <= p_sat;
                        q_reg <= ONE_Q16 - p_sat;
                        j_reg <= '0;
                        i_reg <= 12'd1;
                        if (in_range)
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            res_reg   <= ZERO_Q31;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CLEAR:
                begin
                    j_reg <= j_reg + ROW_AW'(1);
                    if (j_reg == k_reg)
                    begin
                        state_reg <= (n_reg == '0) ? S_RD_RES : S_RD_TOP;
                    end
                end
                S_RD_TOP:
                begin
                    j_reg     <= k_reg;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    cur_reg   <= ram_rd_data;
                    state_reg <= (j_reg == '0) ? S_MUL_Q0 : S_MUL_Q;
                end
                S_MUL_Q:
                begin
                    prod_reg  <= mul_out;
                    lower_reg <= ram_rd_data;
                    state_reg <= S_MUL_P;
                end
                S_MUL_P:
                begin
                    term_reg  <= prod_hi;
                    prod_reg  <= mul_out;
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    cur_reg   <= lower_reg;
                    j_reg     <= j_reg - ROW_AW'(1);
                    state_reg <= (j_reg == ROW_AW'(1)) ? S_MUL_Q0 : S_MUL_Q;
                end
                S_MUL_Q0:
                begin
                    prod_reg  <= mul_out;
                    state_reg <= S_WRITE0;
                end
                S_WRITE0:
                begin
                    i_reg <= i_reg + 12'd1;
                    state_reg <= (i_reg == n_reg) ? S_RD_RES : S_RD_TOP;
                end
                S_RD_RES:
                begin
                    state_reg <= S_RES;
                end
                S_RES:
                begin
                    res_reg   <= ram_rd_data;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        probability_reg <= res_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/bpdp_result_checker.sv
module bpdp_result_checker
    import bpdp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [11:0]       trial_count,
    input  logic [7:0]        success_count,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [VAL_W-1:0]  probability,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [PROB_W-1:0] prob_success,
    output int                mismatch_count,
    output int                outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [11:0]      trials;
        logic [7:0]       successes;
        logic [VAL_W-1:0] prob;
    } binomial_answer_t;

    binomial_answer_t expected_answers [$];
    binomial_answer_t oldest;
    logic [PROB_W-1:0] p_setting = HALF_Q16;

    function automatic logic [VAL_W-1:0] q16_scale(input logic [PROB_W-1:0] w,
                                                   input logic [VAL_W-1:0] v);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(w) * PROD_W'(v);
        return prod[FRAC_P +: VAL_W];
    endfunction

    // Row-by-row recurrence over columns k..0, truncating each product term.
    function automatic logic [VAL_W-1:0] binomial_q31(input logic [11:0] n,
                                                      input logic [7:0] k,
                                                      input logic [PROB_W-1:0] p_cfg);
        logic [VAL_W-1:0]  row [ROW_DEPTH];
        logic [PROB_W-1:0] p;
        logic [PROB_W-1:0] q;
        int i;
        int j;
        p = (p_cfg > ONE_Q16) ? ONE_Q16 : p_cfg;
        q = ONE_Q16 - p;
        if (k > n)
            return ZERO_Q31;
        for (j = 0; j < ROW_DEPTH; j++)
            row[j] = ZERO_Q31;
        row[0] = ONE_Q31;
        for (i = 1; i <= n; i++)
        begin
            for (j = k; j >= 1; j--)
                row[j] = q16_scale(q, row[j]) + q16_scale(p, row[j-1]);
            row[0] = q16_scale(q, row[0]);
        end
        return row[k];
    endfunction

    task automatic report(input string what);
        $display("%0t bpdp_result_checker: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_setting = HALF_Q16;
            expected_answers.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                    report($sformatf("result transfer %h with nothing outstanding",
                                     probability));
                else
                begin
                    oldest = expected_answers.pop_front();
                    if (probability !== oldest.prob)
                        report($sformatf("probability %h, expected %h (n=%0d k=%0d)",
                                         probability, oldest.prob,
                                         oldest.trials, oldest.successes));
                end
            end
            if (in_valid && !in_stall)
                expected_answers.push_back('{trial_count, success_count,
                    binomial_q31(trial_count, success_count, p_setting)});
            if (cfg_valid && cfg_ready)
                p_setting = prob_success;
        end
        outstanding <= expected_answers.size();
    end

endmodule

### tb/binomial_probability_dp_test.sv
module binomial_probability_dp_test;

    import bpdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 70;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [11:0]       trial_count = '0;
    logic [7:0]        success_count = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [VAL_W-1:0]  probability;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [PROB_W-1:0] prob_success = '0;

    int  mismatch_count;
    int  outstanding;
    int  cycle_count = 0;
    int  burst_left = 0;
    logic hold_req = 1'b0;

    int  hold_left = 0;
    bit  hold_used = 1'b0;
    int  stall_mode = 0;
    int  mode_left = 0;

    always #1 clk = ~clk;

    binomial_probability_dp dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .trial_count   (trial_count),
        .success_count (success_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .probability   (probability),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .prob_success  (prob_success)
    );

    bpdp_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .trial_count    (trial_count),
        .success_count  (success_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .probability    (probability),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .prob_success   (prob_success),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("binomial_probability_dp_test: errors");
            $finish;
        end
    end

    // Result side: long hold-off once on request, otherwise a shifting stall pattern.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_used)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            else
                mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic send_request(input logic [11:0] n, input logic [7:0] k);
        trial_count <= n;
        success_count <= k;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic random_request();
        int pick;
        logic [11:0] n;
        logic [7:0]  k;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            n = 12'($urandom_range(0, 24));
            k = 8'($urandom_range(0, (n < 6) ? n + 1 : 6));
        end
        else if (pick < 85)
        begin
            n = 12'($urandom_range(0, 60));
            k = 8'($urandom_range(n + 1, 255));
        end
        else if (pick < 98)
        begin
            n = 12'($urandom_range(25, 300));
            k = 8'($urandom_range(0, 3));
        end
        else
        begin
            n = 12'($urandom_range(2048, 4095));
            k = 8'($urandom_range(0, 1));
        end
        send_request(n, k);
    endtask

    task automatic set_probability(input logic [PROB_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        prob_success <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [PROB_W-1:0] p_value;
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting of p = 0.5
        send_request(12'd0, 8'd0);
        send_request(12'd0, 8'd1);
        send_request(12'd1, 8'd0);
        send_request(12'd1, 8'd1);
        send_request(12'd2, 8'd1);
        send_request(12'd3, 8'd4);
        send_request(12'd5, 8'd5);
        send_request(12'd7, 8'd2);
        send_request(12'd10, 8'd3);
        send_request(12'd10, 8'd10);
        send_request(12'd20, 8'd6);
        send_request(12'd0, 8'd255);
        send_request(12'd254, 8'd255);
        send_request(12'd129, 8'd130);
        send_request(12'd130, 8'd130);
        send_request(12'd100, 8'd50);
        send_request(12'd2048, 8'd1);
        send_request(12'd4095, 8'd0);
        send_request(12'd4095, 8'd3);
        send_request(12'd64, 8'd32);

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: p_value = '0;
                1: p_value = ONE_Q16;
                2: p_value = '1;
                3: p_value = 17'd1;
                4: p_value = PROB_W'($urandom_range(65537, 131070));
                5: p_value = 17'd65535;
                default: p_value = PROB_W'($urandom_range(1, 65535));
            endcase
            set_probability(p_value);
            if (phase == 1)
                hold_req <= 1'b1;
            repeat (PHASE_ITEMS) random_request();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (64) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("binomial_probability_dp_test: clean");
        else
            $display("binomial_probability_dp_test: errors");
        $finish;
    end

endmodule

### sim.f
hdl/bpdp_pkg.sv
hdl/bpdp_ram.sv
hdl/binomial_probability_dp.sv
tb/bpdp_result_checker.sv
tb/binomial_probability_dp_test.sv
